// ----- design/rtkl_pkg.sv -----
// Package for the resource table key lookup block.
// Holds the table geometry, field widths, codes, sequencer states and the result struct.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rtkl_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam int COUNT_W = 11;
  localparam int SLOT_W  = 10;
  localparam int POS_W   = 10;
  localparam int WORD_W  = 32;
  localparam int KEY_W   = 2 * WORD_W;
  localparam int WIDE_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_TABLE_SORTED = 1'b0,
    CFG_ENTRY_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_BOUND,
    S_PROBE,
    S_FINAL,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] size;
  } res_t;

endpackage

`default_nettype wire

// ----- design/resource_table_key_lookup.sv -----
// Top level of the resource table key lookup block: config registers, load path and result register.
// Instantiates rtkl_mem and rtkl_ctrl. Depends on rtkl_pkg.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, cmd_i .. size_word_i   | in
//   result  | out_valid_o, out_stall_i, found_o .. size_out_o| out
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// A load item writes the entry at its accept edge.
// A sorted lookup does two bound reads, then one search step per cycle through the
// single memory read port, then the match read.
// An unsorted lookup reads one entry per cycle, up to n entries; n is the saturated count.
// Reset clears control and config only; table entries are undefined until loaded, no clearing pass.
// A finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module resource_table_key_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [rtkl_pkg::SLOT_W-1:0]   slot_i,
  input  logic [rtkl_pkg::WORD_W-1:0]   res_type_i,
  input  logic [rtkl_pkg::WORD_W-1:0]   res_number_i,
  input  logic [rtkl_pkg::WORD_W-1:0]   file_offset_i,
  input  logic [rtkl_pkg::WORD_W-1:0]   size_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [rtkl_pkg::POS_W-1:0]    position_o,
  output logic [rtkl_pkg::WORD_W-1:0]   offset_out_o,
  output logic [rtkl_pkg::WORD_W-1:0]   size_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [rtkl_pkg::COUNT_W-1:0]  cfg_data_i
);
  import rtkl_pkg::*;

  logic               sorted_q, sorted_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_v_q, out_v_d;
  res_t               out_q;

  logic               in_acc;
  logic               load_we;
  logic               start;
  logic [KEY_W-1:0]   key;
  logic [IDX_W-1:0]   raddr;
  logic [KEY_W-1:0]   rkey;
  logic [KEY_W-1:0]   rloc;
  logic               idle;
  logic               done;
  logic               res_take;
  res_t               res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !idle;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign key         = {res_type_i, res_number_i};
  assign load_we     = in_acc && (cmd_i == CMD_LOAD)
                       && (WIDE_W'(slot_i) < WIDE_W'(TABLE_ENTRIES));
  assign start       = in_acc && (cmd_i == CMD_LOOKUP);
  assign res_take    = done && (!out_v_q || !out_stall_i);

  always_comb begin
    sorted_d = sorted_q;
    count_d  = count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TABLE_SORTED: sorted_d = cfg_data_i[0];
        CFG_ENTRY_COUNT:  count_d  = cfg_data_i;
        default:          sorted_d = sorted_q;
      endcase
    end
  end

  always_comb begin
    out_v_d = out_v_q && out_stall_i;
    if (res_take) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q <= 1'b0;
      count_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      sorted_q <= sorted_d;
      count_q  <= count_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  rtkl_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IDX_W'(slot_i)),
    .wkey_i  (key),
    .wloc_i  ({file_offset_i, size_word_i}),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rloc_o  (rloc)
  );

  rtkl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key_i      (key),
    .sorted_i   (sorted_q),
    .count_i    (count_q),
    .rkey_i     (rkey),
    .rloc_i     (rloc),
    .res_take_i (res_take),
    .raddr_o    (raddr),
    .idle_o     (idle),
    .done_o     (done),
    .res_o      (res)
  );

  assign out_valid_o  = out_v_q;
  assign found_o      = out_q.found;
  assign position_o   = out_q.position;
  assign offset_out_o = out_q.offset;
  assign size_out_o   = out_q.size;

endmodule

`default_nettype wire

// ----- design/rtkl_mem.sv -----
// Key and location stores: two synchronous memories sharing one write and one read address.
// Read data is registered and appears in the cycle after the address. Depends on rtkl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtkl_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rtkl_pkg::IDX_W-1:0]  waddr_i,
  input  logic [rtkl_pkg::KEY_W-1:0]  wkey_i,
  input  logic [rtkl_pkg::KEY_W-1:0]  wloc_i,
  input  logic [rtkl_pkg::IDX_W-1:0]  raddr_i,
  output logic [rtkl_pkg::KEY_W-1:0]  rkey_o,
  output logic [rtkl_pkg::KEY_W-1:0]  rloc_o
);
  import rtkl_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [KEY_W-1:0] loc_mem [TABLE_ENTRIES];
  logic [KEY_W-1:0] rkey_q;
  logic [KEY_W-1:0] rloc_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      loc_mem[waddr_i] <= wloc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[raddr_i];
    rloc_q <= loc_mem[raddr_i];
  end

  assign rkey_o = rkey_q;
  assign rloc_o = rloc_q;

endmodule

`default_nettype wire

// ----- design/rtkl_ctrl.sv -----
// Lookup sequencer: type bound check, lower-bound binary search and linear first-match scan.
// Drives the memory read address and builds one result per lookup. Depends on rtkl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtkl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rtkl_pkg::KEY_W-1:0]   key_i,
  input  logic                         sorted_i,
  input  logic [rtkl_pkg::COUNT_W-1:0] count_i,
  input  logic [rtkl_pkg::KEY_W-1:0]   rkey_i,
  input  logic [rtkl_pkg::KEY_W-1:0]   rloc_i,
  input  logic                         res_take_i,
  output logic [rtkl_pkg::IDX_W-1:0]   raddr_o,
  output logic                         idle_o,
  output logic                         done_o,
  output rtkl_pkg::res_t               res_o
);
  import rtkl_pkg::*;

  state_e            state_q, state_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  half_q, half_d;
  logic [CNT_W-1:0]  mid_q, mid_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              cmp_v_q, cmp_v_d;
  logic              fail_q, fail_d;
  res_t              res_q, res_d;

  logic [CNT_W-1:0]  n_sat;
  logic [WORD_W-1:0] kt;
  logic [WORD_W-1:0] rtype;
  logic              key_lt;
  logic              key_eq;
  logic [CNT_W-1:0]  lo_nx;
  logic [CNT_W-1:0]  len_nx;
  logic [CNT_W-1:0]  half_nx;
  logic [CNT_W-1:0]  mid_nx;
  logic              bound_fail;
  logic              scan_hit;
  logic              scan_end;

  assign n_sat = (WIDE_W'(count_i) > WIDE_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                             : CNT_W'(count_i);
  assign kt         = key_q[KEY_W-1:WORD_W];
  assign rtype      = rkey_i[KEY_W-1:WORD_W];
  assign key_lt     = rkey_i < key_q;
  assign key_eq     = rkey_i == key_q;
  assign lo_nx      = key_lt ? (mid_q + CNT_W'(1)) : lo_q;
  assign len_nx     = key_lt ? (len_q - half_q - CNT_W'(1)) : half_q;
  assign half_nx    = len_nx >> 1;
  assign mid_nx     = lo_nx + half_nx;
  assign bound_fail = fail_q | (rtype < kt);
  assign scan_hit   = cmp_v_q & key_eq;
  assign scan_end   = idx_q == n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (n_sat == '0) begin
            state_d = S_DONE;
          end else if (sorted_i) begin
            state_d = S_FIRST;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FIRST: state_d = S_LAST;
      S_LAST:  state_d = S_BOUND;
      S_BOUND: state_d = bound_fail ? S_DONE : S_PROBE;
      S_PROBE: state_d = (len_nx == '0) ? S_FINAL : S_PROBE;
      S_FINAL: state_d = S_DONE;
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    key_d   = key_q;
    n_d     = n_q;
    lo_d    = lo_q;
    len_d   = len_q;
    half_d  = half_q;
    mid_d   = mid_q;
    idx_d   = idx_q;
    cmp_v_d = cmp_v_q;
    fail_d  = fail_q;
    res_d   = res_q;
    raddr_o = '0;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          n_d     = n_sat;
          idx_d   = '0;
          cmp_v_d = 1'b0;
          res_d   = '0;
        end
      end
      S_FIRST: raddr_o = '0;
      S_LAST: begin
        raddr_o = IDX_W'(n_q - CNT_W'(1));
        fail_d  = rtype > kt;
      end
      S_BOUND: begin
        lo_d    = '0;
        len_d   = n_q;
        half_d  = n_q >> 1;
        mid_d   = n_q >> 1;
        raddr_o = IDX_W'(n_q >> 1);
      end
      S_PROBE: begin
        lo_d    = lo_nx;
        len_d   = len_nx;
        half_d  = half_nx;
        mid_d   = mid_nx;
        raddr_o = (len_nx != '0) ? IDX_W'(mid_nx) : IDX_W'(lo_nx);
      end
      S_FINAL: begin
        if ((lo_q < n_q) && key_eq) begin
          res_d.found    = 1'b1;
          res_d.position = POS_W'(lo_q);
          res_d.offset   = rloc_i[KEY_W-1:WORD_W];
          res_d.size     = rloc_i[WORD_W-1:0];
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_d.found    = 1'b1;
          res_d.position = POS_W'(idx_q - CNT_W'(1));
          res_d.offset   = rloc_i[KEY_W-1:WORD_W];
          res_d.size     = rloc_i[WORD_W-1:0];
        end else if (!scan_end) begin
          raddr_o = IDX_W'(idx_q);
          idx_d   = idx_q + CNT_W'(1);
          cmp_v_d = 1'b1;
        end
      end
      S_DONE: done_o = 1'b1;
      default: done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmp_v_q <= 1'b0;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= cmp_v_d;
      fail_q  <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    n_q    <= n_d;
    lo_q   <= lo_d;
    len_q  <= len_d;
    half_q <= half_d;
    mid_q  <= mid_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  assign idle_o = state_q == S_IDLE;
  assign res_o  = res_q;

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ((len_q != '0) && (mid_q < n_q)))
    else $error("binary search probe outside the valid entries");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= n_q))
    else $error("linear scan ran past the entry count");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_take_i) |=> (done_o && $stable(res_q)))
    else $error("pending result changed before it was taken");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_q.found) |-> ((res_q.position == '0) && (res_q.offset == '0)
                                  && (res_q.size == '0)))
    else $error("not-found result carries nonzero fields");

endmodule

`default_nettype wire
